[src/dme_pkg.sv]
// ----------------------------------------------------------------------------
// dme_pkg
// Shared types and codes of the discernibility matrix engine: the request and
// response payloads, the command, status and register codes, and the states.
// ----------------------------------------------------------------------------
package dme_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTRIBUTE_COUNT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OBJECT_COUNT    = 8'd1;

   localparam logic [6:0] ATTRIBUTE_COUNT_RESET = 7'd1;
   localparam logic [8:0] OBJECT_COUNT_RESET    = 9'd256;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         object;
      logic [7:0]         other_object;
      logic [5:0]         attribute;
      logic               cluster;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] diff_mask;
      logic [15:0] matrix_index;
      logic        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

[src/dme_value_mem.sv]
// ----------------------------------------------------------------------------
// dme_value_mem
// Attribute value store: one write port and two read ports, read data
// registered, so a read returns its word in the cycle after the address.
// ----------------------------------------------------------------------------
module dme_value_mem #(
   parameter int DEPTH      = 16384,
   parameter int ADDR_BITS  = 14,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_BITS-1:0]  waddr,
   input  logic [VALUE_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0]  raddr_a,
   input  logic [ADDR_BITS-1:0]  raddr_b,
   output logic [VALUE_BITS-1:0] rdata_a,
   output logic [VALUE_BITS-1:0] rdata_b
);

   logic [VALUE_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

[src/dme_engine.sv]
// ----------------------------------------------------------------------------
// dme_engine
// Command sequencer: checks a transaction against the configuration, stores
// a value or walks one attribute cluster pair by pair through the value
// memory, builds the difference mask and matrix index, and holds the result.
// ----------------------------------------------------------------------------
module dme_engine #(
   parameter int MAX_OBJECTS    = 256,
   parameter int MAX_ATTRIBUTES = 64,
   parameter int CLUSTER_BITS   = 32,
   parameter int VALUE_BITS     = 16,
   parameter int ADDR_BITS      = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dme_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dme_pkg::rsp_type      rsp_data,
   input  logic [6:0]            cfg_attribute_count,
   input  logic [8:0]            cfg_object_count,
   output logic                  mem_we,
   output logic [ADDR_BITS-1:0]  mem_waddr,
   output logic [VALUE_BITS-1:0] mem_wdata,
   output logic [ADDR_BITS-1:0]  mem_raddr_a,
   output logic [ADDR_BITS-1:0]  mem_raddr_b,
   input  logic [VALUE_BITS-1:0] mem_rdata_a,
   input  logic [VALUE_BITS-1:0] mem_rdata_b
);

   localparam int IDX_BITS     = $clog2(CLUSTER_BITS);
   localparam int MAX_CLUSTERS = (MAX_ATTRIBUTES + CLUSTER_BITS - 1) / CLUSTER_BITS;
   localparam int CLU_BITS     = $clog2(MAX_CLUSTERS + 1);
   localparam int NA_BITS      = $clog2(MAX_ATTRIBUTES + 1);
   localparam int NO_BITS      = $clog2(MAX_OBJECTS + 1);
   localparam logic [VALUE_BITS-1:0] MISSING = '1;

   dme_pkg::state_type    state_ff, state_in;
   dme_pkg::req_type      req_ff, req_in;
   dme_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  status_ff, status_in;
   logic                  ok_ff, ok_in;
   logic [IDX_BITS-1:0]   last_ff, last_in;
   logic [IDX_BITS-1:0]   i_ff, i_in;
   logic [ADDR_BITS-1:0]  row_addr_ff, row_addr_in;
   logic [ADDR_BITS-1:0]  col_addr_ff, col_addr_in;
   logic [15:0]           tri_ff, tri_in;
   logic [CLU_BITS-1:0]   clusters_ff, clusters_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IDX_BITS-1:0]   pend_bit_ff, pend_bit_in;
   logic [31:0]           mask_ff, mask_in;

   logic [NA_BITS-1:0]      na_eff;
   logic [NO_BITS-1:0]      no_eff;
   logic [MAX_CLUSTERS-1:0] cluster_used;
   logic                    write_ok, query_ok;
   logic [31:0]             remaining;
   logic signed [31:0]      value_ext;
   logic                    hit, slot_free, rsp_load, issue;
   logic [15:0]             index_value;

   // Effective configuration, register values saturated into range.
   always_comb begin
      if (cfg_attribute_count == 7'd0) begin
         na_eff = NA_BITS'(1);
      end else if (32'(cfg_attribute_count) > 32'(MAX_ATTRIBUTES)) begin
         na_eff = NA_BITS'(MAX_ATTRIBUTES);
      end else begin
         na_eff = NA_BITS'(cfg_attribute_count);
      end
      if (cfg_object_count == 9'd0) begin
         no_eff = NO_BITS'(1);
      end else if (32'(cfg_object_count) > 32'(MAX_OBJECTS)) begin
         no_eff = NO_BITS'(MAX_OBJECTS);
      end else begin
         no_eff = NO_BITS'(cfg_object_count);
      end
      // A cluster is in use when at least one of its attributes is.
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
         cluster_used[k] = 32'(na_eff) > 32'(k * CLUSTER_BITS);
      end
      clusters_in = CLU_BITS'($countones(cluster_used));
   end

   always_comb begin
      write_ok  = (32'(req_ff.object) < 32'(no_eff))
               && (32'(req_ff.attribute) < 32'(na_eff));
      query_ok  = (32'(req_ff.object) < 32'(no_eff))
               && (req_ff.other_object < req_ff.object)
               && (32'(req_ff.cluster) < 32'(clusters_in));
      remaining = 32'(na_eff) - 32'd1 - 32'(req_ff.cluster) * 32'(CLUSTER_BITS);
      if (remaining >= 32'(CLUSTER_BITS - 1)) begin
         last_in = IDX_BITS'(CLUSTER_BITS - 1);
      end else begin
         last_in = IDX_BITS'(remaining);
      end
      row_addr_in = ADDR_BITS'(32'(req_ff.object) * 32'(MAX_ATTRIBUTES)
                  + 32'(req_ff.cluster) * 32'(CLUSTER_BITS));
      col_addr_in = ADDR_BITS'(32'(req_ff.other_object) * 32'(MAX_ATTRIBUTES)
                  + 32'(req_ff.cluster) * 32'(CLUSTER_BITS));
      tri_in = 16'(((32'(req_ff.object) * (32'(req_ff.object) - 32'd1)) >> 1)
             + 32'(req_ff.other_object));
      value_ext = 32'(req_ff.value);
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dme_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dme_pkg::ST_CHECK;
            end
         end
         dme_pkg::ST_CHECK: begin
            if (req_ff.cmd == dme_pkg::CMD_QUERY && query_ok) begin
               state_in = dme_pkg::ST_READ;
            end else begin
               state_in = dme_pkg::ST_FINISH;
            end
         end
         dme_pkg::ST_READ: begin
            if (i_ff == last_ff) begin
               state_in = dme_pkg::ST_DRAIN;
            end
         end
         dme_pkg::ST_DRAIN: begin
            state_in = dme_pkg::ST_FINISH;
         end
         dme_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = dme_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dme_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         dme_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         dme_pkg::ST_CHECK: begin
            mem_we = (req_ff.cmd == dme_pkg::CMD_WRITE) && write_ok;
         end
         dme_pkg::ST_READ: begin
            issue = 1'b1;
         end
         dme_pkg::ST_DRAIN: begin
            issue = 1'b0;
         end
         dme_pkg::ST_FINISH: begin
            rsp_load = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign mem_waddr   = ADDR_BITS'(32'(req_ff.object) * 32'(MAX_ATTRIBUTES)
                      + 32'(req_ff.attribute));
   assign mem_wdata   = value_ext[VALUE_BITS-1:0];
   assign mem_raddr_a = row_addr_ff + ADDR_BITS'(i_ff);
   assign mem_raddr_b = col_addr_ff + ADDR_BITS'(i_ff);

   assign hit = (mem_rdata_a != mem_rdata_b) && (mem_rdata_a != MISSING)
             && (mem_rdata_b != MISSING);

   assign index_value = ok_ff
                      ? 16'(32'(tri_ff) * 32'(clusters_ff) + 32'(req_ff.cluster))
                      : 16'd0;

   // Datapath next values.
   always_comb begin
      req_in        = req_ff;
      status_in     = status_ff;
      ok_in         = ok_ff;
      i_in          = i_ff;
      mask_in       = mask_ff;
      pend_valid_in = issue;
      pend_bit_in   = i_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (state_ff == dme_pkg::ST_IDLE && req_valid) begin
         req_in = req_data;
      end
      if (state_ff == dme_pkg::ST_CHECK) begin
         i_in    = '0;
         mask_in = '0;
         ok_in   = (req_ff.cmd == dme_pkg::CMD_QUERY) && query_ok;
         if (req_ff.cmd == dme_pkg::CMD_QUERY) begin
            status_in = query_ok ? dme_pkg::STATUS_OK : dme_pkg::STATUS_REJECT;
         end else begin
            status_in = write_ok ? dme_pkg::STATUS_OK : dme_pkg::STATUS_REJECT;
         end
      end
      if (issue) begin
         i_in = i_ff + IDX_BITS'(1);
      end
      // Read data lands in the cycle after its address; bits past 31 are dropped.
      if (pend_valid_ff && hit) begin
         for (int k = 0; k < 32; k++) begin
            if (32'(pend_bit_ff) == 32'(k)) begin
               mask_in[k] = 1'b1;
            end
         end
      end
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.diff_mask    = mask_ff;
         rsp_data_in.matrix_index = index_value;
         rsp_data_in.status       = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dme_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      status_ff   <= status_in;
      ok_ff       <= ok_in;
      i_ff        <= i_in;
      mask_ff     <= mask_in;
      pend_bit_ff <= pend_bit_in;
      if (state_ff == dme_pkg::ST_CHECK) begin
         last_ff     <= last_in;
         row_addr_ff <= row_addr_in;
         col_addr_ff <= col_addr_in;
         tri_ff      <= tri_in;
         clusters_ff <= clusters_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_write_only_on_check: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == dme_pkg::ST_CHECK && req_ff.cmd == dme_pkg::CMD_WRITE))
      else $error("value store written outside a write transaction");

   a_reject_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == dme_pkg::STATUS_REJECT)
      |-> (rsp_data_ff.diff_mask == 32'd0 && rsp_data_ff.matrix_index == 16'd0))
      else $error("rejected response carries a mask or index");

   a_pending_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == dme_pkg::ST_READ || state_ff == dme_pkg::ST_DRAIN))
      else $error("read data returned outside the cluster walk");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dme_pkg::ST_READ) |-> (i_ff <= last_ff))
      else $error("attribute counter ran past the cluster end");
`endif

endmodule

[src/discernibility_matrix_engine.sv]
// ----------------------------------------------------------------------------
// discernibility_matrix_engine
// Attribute value table with pairwise discernibility queries over one cluster.
// ----------------------------------------------------------------------------
// A write transaction stores one attribute value. It and a rejected transaction
// pass through the check and finish states, and the result is loaded into the
// output register as the engine returns to idle for the next request. A query
// passes through the check state, the read state once for each of the n
// attributes in use in the requested cluster (at most CLUSTER_BITS), the drain
// state and the finish state, because the value memory delivers one attribute
// pair per cycle on its two read ports. One transaction is in work at a time;
// a finished result waits in the output register while the next request is
// taken. When a new result is ready while the previous one is still stalled,
// the engine waits in its finish state while the output stays stalled and
// holds off the request channel. Stored values are undefined until written
// and the store needs no clearing after reset. Configuration writes are always
// ready and must be made while idle.
module discernibility_matrix_engine #(
   parameter int MAX_OBJECTS    = 256,
   parameter int MAX_ATTRIBUTES = 64,
   parameter int CLUSTER_BITS   = 32,
   parameter int VALUE_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dme_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dme_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dme_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dme_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int STORE_DEPTH = MAX_OBJECTS * MAX_ATTRIBUTES;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   logic [6:0] attribute_count_ff, attribute_count_in;
   logic [8:0] object_count_ff, object_count_in;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr, mem_raddr_a, mem_raddr_b;
   logic [VALUE_BITS-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

   assign csr_ready = 1'b1;

   always_comb begin
      attribute_count_in = attribute_count_ff;
      object_count_in    = object_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dme_pkg::CSR_ATTRIBUTE_COUNT: attribute_count_in = csr_data[6:0];
            dme_pkg::CSR_OBJECT_COUNT:    object_count_in    = csr_data[8:0];
            default: begin
               attribute_count_in = attribute_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_count_ff <= dme_pkg::ATTRIBUTE_COUNT_RESET;
         object_count_ff    <= dme_pkg::OBJECT_COUNT_RESET;
      end else begin
         attribute_count_ff <= attribute_count_in;
         object_count_ff    <= object_count_in;
      end
   end

   dme_value_mem #(
      .DEPTH      (STORE_DEPTH),
      .ADDR_BITS  (ADDR_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_value_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   dme_engine #(
      .MAX_OBJECTS    (MAX_OBJECTS),
      .MAX_ATTRIBUTES (MAX_ATTRIBUTES),
      .CLUSTER_BITS   (CLUSTER_BITS),
      .VALUE_BITS     (VALUE_BITS),
      .ADDR_BITS      (ADDR_BITS)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data            (rsp_data),
      .cfg_attribute_count (attribute_count_ff),
      .cfg_object_count    (object_count_ff),
      .mem_we              (mem_we),
      .mem_waddr           (mem_waddr),
      .mem_wdata           (mem_wdata),
      .mem_raddr_a         (mem_raddr_a),
      .mem_raddr_b         (mem_raddr_b),
      .mem_rdata_a         (mem_rdata_a),
      .mem_rdata_b         (mem_rdata_b)
   );

endmodule
